FILE: design/fifo_page_buffer_directory_core_macros.svh
// assertion helpers shared by the checker
`ifndef FIFO_PAGE_BUFFER_DIRECTORY_CORE_MACROS_SVH
`define FIFO_PAGE_BUFFER_DIRECTORY_CORE_MACROS_SVH

// same-cycle implication, off while in reset
`define FPBD_ASSERT_NOW(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (expr)) \
        else $error("fpbd check failed (same cycle)");

// next-cycle implication, off while in reset
`define FPBD_ASSERT_NEXT(label, clk, rstn, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (expr)) \
        else $error("fpbd check failed (next cycle)");

`endif

FILE: design/fpbd_pkg.sv
package fpbd_pkg;

    localparam int PAGE_W  = 20;
    localparam int TOTAL_W = 21;
    localparam int SLOTS_W = 5;
    localparam int OSLOT_W = 4;

    // result codes
    typedef enum logic [1:0] {
        ST_HIT        = 2'd0,
        ST_MISS_FREE  = 2'd1,
        ST_MISS_EVICT = 2'd2,
        ST_INVALID    = 2'd3
    } fpbd_status_t;

    // register indexes of the config port
    localparam logic REG_SLOTS_IN_USE = 1'b0;
    localparam logic REG_PAGE_LIMIT   = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_PUSH
    } fpbd_state_t;

    // lookup token walking down the cell chain
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
        logic              hit;
        logic [PAGE_W-1:0] victim_tag;
    } fpbd_probe_t;

    // broadcast tag write
    typedef struct packed {
        logic              en;
        logic [PAGE_W-1:0] page;
    } fpbd_write_t;

endpackage

FILE: design/fpbd_cell.sv
module fpbd_cell #(
    parameter int MAX_SLOTS = 16,
    parameter int INDEX     = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fpbd_pkg::fpbd_probe_t         probe_in,
    input  logic [$clog2(MAX_SLOTS)-1:0]  hit_slot_in,
    input  logic [$clog2(MAX_SLOTS)-1:0]  victim_slot,
    input  fpbd_pkg::fpbd_write_t         wr,
    input  logic [$clog2(MAX_SLOTS)-1:0]  wr_slot,
    output fpbd_pkg::fpbd_probe_t         probe_out,
    output logic [$clog2(MAX_SLOTS)-1:0]  hit_slot_out
);
    import fpbd_pkg::*;

    localparam int SW = $clog2(MAX_SLOTS);
    localparam logic [SW-1:0] MY_IDX = SW'(INDEX);

    logic [PAGE_W-1:0] tag_reg;
    logic              valid_reg;
    fpbd_probe_t       probe_reg;
    fpbd_probe_t       probe_next;
    logic [SW-1:0]     hit_slot_reg;
    logic [SW-1:0]     hit_slot_next;
    logic              match;

    // first match wins: a hit from a lower cell passes through untouched
    always_comb begin
        match                 = valid_reg && (tag_reg == probe_in.page);
        probe_next            = probe_in;
        probe_next.hit        = probe_in.hit | match;
        hit_slot_next         = probe_in.hit ? hit_slot_in : MY_IDX;
        if (victim_slot == MY_IDX) begin
            probe_next.victim_tag = tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= 1'b0;
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg.valid <= probe_next.valid;
            if (wr.en && (wr_slot == MY_IDX)) begin
                valid_reg <= 1'b1;
            end
        end
        probe_reg.page       <= probe_next.page;
        probe_reg.hit        <= probe_next.hit;
        probe_reg.victim_tag <= probe_next.victim_tag;
        hit_slot_reg         <= hit_slot_next;
        if (wr.en && (wr_slot == MY_IDX)) begin
            tag_reg <= wr.page;
        end
    end

    assign probe_out    = probe_reg;
    assign hit_slot_out = hit_slot_reg;

endmodule

FILE: design/fifo_page_buffer_directory_core.sv
// page buffer pool directory with first-in first-out replacement
//
// s_ channel: one page number per transaction; m_ channel: status, slot and
// evicted page for each request, exactly one result per request, in order.
// cfg channel: cfg_index 0 sets slots_in_use, 1 sets the page limit; always
// ready; the user must write it only while the block is idle, not checked.
//
// each request walks a chain of MAX_SLOTS cells, one cell per cycle; each
// cell holds one slot tag, checks for a hit and picks up the victim tag.
// an accepted valid page passes the cell registers, the pending result
// registers and the output register before it shows on m_; an invalid page
// skips the walk and goes to the pending result registers directly. the next
// request is taken only once the block is back in its idle state.
//
// reset clears all slot valid bits, the fill count and the round-robin
// pointer at once; slots_in_use returns to 16 and the page limit to 0.
// a stalled m_ side holds its result in the output register; the next result
// waits in the pending registers with the block parked in its push state,
// and no new request is taken until the output register frees up.
module fifo_page_buffer_directory_core #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [fpbd_pkg::PAGE_W-1:0]    s_page_number,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic [fpbd_pkg::OSLOT_W-1:0]   m_slot,
    output logic [fpbd_pkg::PAGE_W-1:0]    m_evicted_page,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_index,
    input  logic [fpbd_pkg::TOTAL_W-1:0]   cfg_data
);
    import fpbd_pkg::*;

    localparam int SW   = $clog2(MAX_SLOTS);
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int CAPW = (CW > SLOTS_W) ? CW : SLOTS_W;
    localparam int XW   = (SW > OSLOT_W) ? SW : OSLOT_W;

    // control and config state
    fpbd_state_t           state_reg, state_next;
    logic [SLOTS_W-1:0]    slots_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [CW-1:0]         fill_reg, fill_next;
    logic [SW-1:0]         oldest_reg, oldest_next;

    // pending result, waiting for the output register
    fpbd_status_t          res_status_reg, res_status_next;
    logic [OSLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [PAGE_W-1:0]     res_evict_reg, res_evict_next;

    // output register
    logic                  m_valid_reg, m_valid_next;
    fpbd_status_t          m_status_reg;
    logic [OSLOT_W-1:0]    m_slot_reg;
    logic [PAGE_W-1:0]     m_evict_reg;

    // cell chain wiring
    fpbd_probe_t           probe_w [0:MAX_SLOTS];
    logic [SW-1:0]         hit_slot_w [0:MAX_SLOTS];
    fpbd_write_t           wr;
    logic [SW-1:0]         wr_slot;

    logic                  s_accept;
    logic                  page_invalid;
    logic [CAPW-1:0]       slots_ext;
    logic [CAPW-1:0]       cap;
    logic                  miss_free;
    logic [SW-1:0]         victim;
    logic [CW-1:0]         victim_inc;
    logic [XW-1:0]         slot_ext;
    logic                  out_load;
    fpbd_probe_t           probe_last;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;

    // page at or above the page limit is rejected
    assign page_invalid = ({1'b0, s_page_number} >= total_reg);

    // effective capacity: zero acts as one, clamp to the chain length
    assign slots_ext = CAPW'(slots_reg);
    always_comb begin
        if (slots_reg == '0) begin
            cap = CAPW'(1);
        end else if (slots_ext > CAPW'(MAX_SLOTS)) begin
            cap = CAPW'(MAX_SLOTS);
        end else begin
            cap = slots_ext;
        end
    end

    assign miss_free  = (CAPW'(fill_reg) < cap);
    // pointer beyond the filled slots falls back to slot zero
    assign victim     = (CW'(oldest_reg) >= fill_reg) ? '0 : oldest_reg;
    assign victim_inc = CW'(victim) + CW'(1);

    // token launched into the first cell on a valid request
    always_comb begin
        probe_w[0].valid      = s_accept && !page_invalid;
        probe_w[0].page       = s_page_number;
        probe_w[0].hit        = 1'b0;
        probe_w[0].victim_tag = '0;
        hit_slot_w[0]         = '0;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
            fpbd_cell #(
                .MAX_SLOTS (MAX_SLOTS),
                .INDEX     (gi)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .probe_in     (probe_w[gi]),
                .hit_slot_in  (hit_slot_w[gi]),
                .victim_slot  (victim),
                .wr           (wr),
                .wr_slot      (wr_slot),
                .probe_out    (probe_w[gi+1]),
                .hit_slot_out (hit_slot_w[gi+1])
            );
        end
    endgenerate

    assign probe_last = probe_w[MAX_SLOTS];

    // output register is free when empty or being drained
    assign out_load = (state_reg == S_PUSH) && (!m_valid_reg || m_ready);

    // sequencer: next state, directory update and pending result
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        oldest_next     = oldest_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_evict_next  = res_evict_reg;
        wr.en           = 1'b0;
        wr.page         = probe_last.page;
        wr_slot         = victim;
        slot_ext        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (page_invalid) begin
                        res_status_next = ST_INVALID;
                        res_slot_next   = '0;
                        res_evict_next  = '0;
                        state_next      = S_PUSH;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (probe_last.valid) begin
                    if (probe_last.hit) begin
                        res_status_next = ST_HIT;
                        slot_ext        = XW'(hit_slot_w[MAX_SLOTS]);
                        res_evict_next  = '0;
                    end else if (miss_free) begin
                        // fill the next free slot
                        res_status_next = ST_MISS_FREE;
                        wr.en           = 1'b1;
                        wr_slot         = fill_reg[SW-1:0];
                        slot_ext        = XW'(fill_reg[SW-1:0]);
                        res_evict_next  = '0;
                        fill_next       = fill_reg + CW'(1);
                    end else begin
                        // replace the oldest slot, step round robin
                        res_status_next = ST_MISS_EVICT;
                        wr.en           = 1'b1;
                        wr_slot         = victim;
                        slot_ext        = XW'(victim);
                        res_evict_next  = probe_last.victim_tag;
                        oldest_next     = (victim_inc >= fill_reg) ? '0 : victim_inc[SW-1:0];
                    end
                    res_slot_next = slot_ext[OSLOT_W-1:0];
                    state_next    = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            m_valid_reg <= 1'b0;
            slots_reg   <= SLOTS_W'(16);
            total_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            oldest_reg  <= oldest_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SLOTS_IN_USE: slots_reg <= cfg_data[SLOTS_W-1:0];
                    REG_PAGE_LIMIT:   total_reg <= cfg_data;
                    default:          total_reg <= total_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_evict_reg  <= res_evict_next;
        if (out_load) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_evict_reg  <= res_evict_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_slot         = m_slot_reg;
    assign m_evicted_page = m_evict_reg;

endmodule

FILE: design/fpbd_checker.sv
`include "fifo_page_buffer_directory_core_macros.svh"

module fpbd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [fpbd_pkg::PAGE_W-1:0]   s_page_number,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_status,
    input logic [fpbd_pkg::OSLOT_W-1:0]  m_slot,
    input logic [fpbd_pkg::PAGE_W-1:0]   m_evicted_page
);
    import fpbd_pkg::*;

    // one request in flight at a time
    `FPBD_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // a stalled result holds its payload
    `FPBD_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_slot) && $stable(m_evicted_page))

    // invalid page reports slot zero and no eviction
    `FPBD_ASSERT_NOW(a_invalid_zero, aclk, aresetn, m_valid && (m_status == ST_INVALID), (m_slot == '0) && (m_evicted_page == '0))

    // evicted page only on an eviction
    `FPBD_ASSERT_NOW(a_evict_only, aclk, aresetn, m_valid && (m_status != ST_MISS_EVICT), m_evicted_page == '0)

endmodule

bind fifo_page_buffer_directory_core fpbd_checker u_fpbd_checker (.*);
